// ===== hw/rtl/lmrp_pkg.sv =====
package lmrp_pkg;

    localparam logic [7:0] HDR_BYTE_0 = 8'h6F;
    localparam logic [7:0] HDR_BYTE_1 = 8'h20;
    localparam logic [7:0] HDR_BYTE_2 = 8'h6C;
    localparam logic [7:0] HDR_BYTE_3 = 8'h6F;
    localparam logic [7:0] TYPE_LOAD  = 8'h01;
    localparam logic [7:0] TYPE_XFER  = 8'h02;
    localparam logic [7:0] TYPE_MAX   = 8'h1F;
    localparam logic [7:0] XFER_MARK  = 8'h02;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_TYPE = 2'd1;
    localparam logic [1:0] ST_BAD_MARK = 2'd2;
    localparam logic [1:0] ST_TRUNC    = 2'd3;

    typedef enum logic [3:0] {
        PH_FIRST,
        PH_HDR,
        PH_TYPE,
        PH_COUNT,
        PH_ALO,
        PH_AHI,
        PH_DATA,
        PH_XMARK,
        PH_XLO,
        PH_XHI,
        PH_SKIPLEN,
        PH_SKIP,
        PH_DONE_OK,
        PH_DONE_T,
        PH_DONE_M
    } phase_t;

    typedef enum logic [1:0] {
        TK_LOAD,
        TK_XFER,
        TK_SKIP,
        TK_BAD
    } type_kind_t;

    typedef struct packed {
        logic [7:0] image_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic        write_valid;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic        finished;
        logic [1:0]  status;
        logic        transfer_valid;
        logic [15:0] transfer_address;
    } out_word_t;

    // byte plus the decode the parser needs from it
    typedef struct packed {
        logic [7:0] image_byte;
        logic       last_byte;
        logic [3:0] hdr_hit;
        type_kind_t kind;
        logic       is_zero;
        logic       is_xmark;
        logic [8:0] count_left;
    } class_word_t;

endpackage

// ===== hw/rtl/lmrp_front.sv =====
module lmrp_front
    import lmrp_pkg::*;
(
    input  in_word_t    word,
    output class_word_t cls
);

    logic [7:0] b;

    assign b = word.image_byte;

    always_comb
    begin
        cls.image_byte = b;
        cls.last_byte  = word.last_byte;
        cls.hdr_hit[0] = (b == HDR_BYTE_0);
        cls.hdr_hit[1] = (b == HDR_BYTE_1);
        cls.hdr_hit[2] = (b == HDR_BYTE_2);
        cls.hdr_hit[3] = (b == HDR_BYTE_3);
        if (b == TYPE_LOAD)
            cls.kind = TK_LOAD;
        else if (b == TYPE_XFER)
            cls.kind = TK_XFER;
        else if (b > TYPE_MAX)
            cls.kind = TK_BAD;
        else
            cls.kind = TK_SKIP;
        cls.is_zero  = (b == 8'h00);
        cls.is_xmark = (b == XFER_MARK);
        // counts 0..2 stand for 256..258; two counted bytes are the address
        if (b <= 8'd2)
            cls.count_left = {1'b0, b} + 9'd254;
        else
            cls.count_left = {1'b0, b} - 9'd2;
    end

endmodule

// ===== hw/rtl/lmrp_queue.sv =====
module lmrp_queue
    import lmrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  class_word_t push_word,
    output logic        full,
    input  logic        pop,
    output logic        not_empty,
    output class_word_t head
);

    class_word_t entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        do_push;
    logic        do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_word;
    end

endmodule

// ===== hw/rtl/lmrp_back.sv =====
module lmrp_back
    import lmrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cls_valid,
    input  class_word_t cls,
    output logic        cls_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output out_word_t   out_word
);

    phase_t      phase_reg;
    phase_t      phase_next;
    phase_t      phase_store;
    logic [8:0]  data_left_reg;
    logic [8:0]  data_left_next;
    logic [15:0] load_addr_reg;
    logic [15:0] load_addr_next;
    logic [7:0]  skip_left_reg;
    logic [7:0]  skip_left_next;
    logic [15:0] entry_addr_reg;
    logic [15:0] entry_addr_next;
    logic        entry_known_reg;
    logic        entry_known_next;
    logic        wr_en;
    logic        advance;
    logic        out_valid_reg;
    out_word_t   out_word_reg;
    out_word_t   result;
    logic [7:0]  b;

    assign b         = cls.image_byte;
    assign advance   = cls_valid && (!out_valid_reg || out_ready);
    assign cls_pop   = advance;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    function automatic phase_t type_phase(input type_kind_t k);
        case (k)
            TK_LOAD: type_phase = PH_COUNT;
            TK_XFER: type_phase = PH_XMARK;
            TK_BAD:  type_phase = PH_DONE_T;
            default: type_phase = PH_SKIPLEN;
        endcase
    endfunction

    // next state
    always_comb
    begin
        phase_next       = phase_reg;
        data_left_next   = data_left_reg;
        load_addr_next   = load_addr_reg;
        skip_left_next   = skip_left_reg;
        entry_addr_next  = entry_addr_reg;
        entry_known_next = entry_known_reg;
        wr_en            = 1'b0;
        case (phase_reg)
            PH_FIRST, PH_TYPE:
            begin
                if (phase_reg == PH_FIRST && cls.hdr_hit[0])
                begin
                    skip_left_next = 8'd1;
                    phase_next     = PH_HDR;
                end
                else
                begin
                    phase_next = type_phase(cls.kind);
                    if (cls.kind == TK_SKIP)
                        skip_left_next = b;
                end
            end
            PH_HDR:
            begin
                if (!cls.hdr_hit[skip_left_reg[1:0]])
                    phase_next = PH_DONE_T;
                else
                begin
                    skip_left_next = skip_left_reg + 8'd1;
                    if (skip_left_reg[1:0] == 2'd3)
                        phase_next = PH_TYPE;
                end
            end
            PH_COUNT:
            begin
                data_left_next = cls.count_left;
                phase_next     = PH_ALO;
            end
            PH_ALO, PH_XLO:
            begin
                load_addr_next = {8'h00, b};
                phase_next     = (phase_reg == PH_ALO) ? PH_AHI : PH_XHI;
            end
            PH_AHI:
            begin
                load_addr_next = {b, load_addr_reg[7:0]};
                phase_next     = (data_left_reg == 9'd0) ? PH_TYPE : PH_DATA;
            end
            PH_DATA:
            begin
                wr_en          = 1'b1;
                load_addr_next = load_addr_reg + 16'd1;
                data_left_next = data_left_reg - 9'd1;
                if (data_left_reg == 9'd1)
                    phase_next = PH_TYPE;
            end
            PH_XMARK:
                phase_next = cls.is_xmark ? PH_XLO : PH_DONE_M;
            PH_XHI:
            begin
                entry_addr_next  = {b, load_addr_reg[7:0]};
                entry_known_next = 1'b1;
                phase_next       = PH_TYPE;
            end
            PH_SKIPLEN:
            begin
                // type 0 with zero length ends the image
                if (cls.is_zero && skip_left_reg == 8'd0)
                    phase_next = PH_DONE_OK;
                else
                begin
                    skip_left_next = b;
                    phase_next     = cls.is_zero ? PH_TYPE : PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                skip_left_next = skip_left_reg - 8'd1;
                if (skip_left_reg == 8'd1)
                    phase_next = PH_TYPE;
            end
            default:
                ;
        endcase
        phase_store = cls.last_byte ? PH_FIRST : phase_next;
    end

    // result word
    always_comb
    begin
        result.write_valid      = wr_en;
        result.write_address    = wr_en ? load_addr_reg : 16'h0000;
        result.write_data       = wr_en ? b : 8'h00;
        result.transfer_valid   = entry_known_next;
        result.transfer_address = entry_addr_next;
        result.finished         = 1'b1;
        case (phase_next)
            PH_DONE_T:  result.status = ST_BAD_TYPE;
            PH_DONE_M:  result.status = ST_BAD_MARK;
            PH_DONE_OK: result.status = ST_OK;
            default:
            begin
                result.finished = cls.last_byte;
                if (cls.last_byte && phase_next != PH_TYPE)
                    result.status = ST_TRUNC;
                else
                    result.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_FIRST;
            data_left_reg   <= 9'd0;
            load_addr_reg   <= 16'h0000;
            skip_left_reg   <= 8'd0;
            entry_addr_reg  <= 16'h0000;
            entry_known_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg       <= phase_store;
                data_left_reg   <= cls.last_byte ? 9'd0 : data_left_next;
                load_addr_reg   <= load_addr_next;
                skip_left_reg   <= cls.last_byte ? 8'd0 : skip_left_next;
                entry_addr_reg  <= entry_addr_next;
                entry_known_reg <= entry_known_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_word_reg <= result;
    end

    a_err_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_word_reg.status != ST_OK |-> out_word_reg.finished)
        else $error("error status without finished");

    a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> data_left_reg != 9'd0)
        else $error("data phase with no bytes left");

    a_hdr_index: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HDR |-> skip_left_reg != 8'd0 && skip_left_reg <= 8'd3)
        else $error("header index out of range");

    a_entry_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        entry_known_reg |=> entry_known_reg)
        else $error("transfer valid dropped without reset");

    a_write_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_word_reg.write_valid |->
            out_word_reg.write_address == 16'h0000 && out_word_reg.write_data == 8'h00)
        else $error("write payload set without write");

endmodule

// ===== hw/rtl/load_module_record_parser.sv =====
// Load-module record parser.
// in_valid/in_ready/in_word carry one image byte per word, with last_byte
// marking the final byte of an image. out_valid/out_ready/out_word return
// exactly one result word per input word, in order: an optional memory
// write plus finished, status and the latest transfer address.
// Throughput is one word per cycle while out_ready is high. An accepted word is
// decoded and queued in a two-entry queue, parsed from the queue head, and its
// result is registered in the output register that drives out_word; the
// parser state register is the one-byte-per-cycle loop.
// When out_ready is low the result holds in the output register and
// the queue absorbs up to two more words before in_ready drops.
// Reset empties the queue and the output register, returns the parser to
// the start of an image and clears the transfer address and its valid bit.
// After a last_byte word the next word starts a new image; the transfer
// address survives across images.
module load_module_record_parser
    import lmrp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    class_word_t cls_in;
    class_word_t cls_head;
    logic        q_full;
    logic        q_not_empty;
    logic        q_pop;

    assign in_ready = !q_full;

    lmrp_front u_front (
        .word (in_word),
        .cls  (cls_in)
    );

    lmrp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_word (cls_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (cls_head)
    );

    lmrp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_valid (q_not_empty),
        .cls       (cls_head),
        .cls_pop   (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule
